### hdl/cspd_pkg.sv
// Shared constants, word table, types and helpers of the C source payload detector.
package cspd_pkg;

   localparam int WINDOW        = 16;
   localparam int COUNT_BITS    = 16;
   localparam int BUF_LEN       = WINDOW + 1;
   localparam int FILL_BITS     = $clog2(BUF_LEN + 1);
   localparam int KW_COUNT      = 7;
   localparam int KW_IDX_BITS   = $clog2(KW_COUNT);
   localparam int DISTINCT_BITS = $clog2(KW_COUNT + 1);
   localparam int KSUM_BITS     = COUNT_BITS + 3;
   localparam int RATIO_BITS    = 8;
   localparam int PROD_BITS     = COUNT_BITS + RATIO_BITS;
   localparam int MIN_BITS      = 16;
   localparam int CMP_BITS      = (KSUM_BITS > MIN_BITS) ? KSUM_BITS : MIN_BITS;
   localparam int WORD_COUNT    = 14;
   localparam int WORD_IDX_BITS = $clog2(WORD_COUNT);
   localparam int WORD_MAX_LEN  = 9;
   localparam int SKIP_BITS     = $clog2(WORD_MAX_LEN);

   // port field widths
   localparam int BYTE_BITS      = 8;
   localparam int TOTAL_BITS     = 16;
   localparam int SUM_BITS       = 19;
   localparam int DIST_OUT_BITS  = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [BYTE_BITS-1:0] CHAR_LF   = 8'h0a;
   localparam logic [BYTE_BITS-1:0] CHAR_CR   = 8'h0d;
   localparam logic [BYTE_BITS-1:0] CHAR_SEMI = 8'h3b;
   localparam logic [BYTE_BITS-1:0] CHAR_DASH = 8'h2d;
   localparam logic [BYTE_BITS-1:0] CHAR_GT   = 8'h3e;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SEMI_SCALE       = 3'd0,
      CSR_LINES_MINIMUM    = 3'd1,
      CSR_ARROWS_MINIMUM   = 3'd2,
      CSR_PREPROC_MINIMUM  = 3'd3,
      CSR_KEYWORDS_MINIMUM = 3'd4,
      CSR_CALLS_MINIMUM    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      GROUP_PREPROC,
      GROUP_KEYWORD,
      GROUP_CALL
   } word_group_type;

   // strings are right-justified: first character in the highest used byte
   localparam logic [BYTE_BITS*WORD_MAX_LEN-1:0] WORD_TEXT [WORD_COUNT] = '{
      "#define", "#include",
      "struct ", "enum ", "typedef ", "sizeof", "volatile ", "goto ", "void ",
      "printf(", "strcmp(", "strlen(", "malloc(", "scanf("
   };
   localparam int WORD_LEN [WORD_COUNT] = '{7, 8, 7, 5, 8, 6, 9, 5, 5, 7, 7, 7, 7, 6};
   localparam word_group_type WORD_GROUP [WORD_COUNT] = '{
      GROUP_PREPROC, GROUP_PREPROC,
      GROUP_KEYWORD, GROUP_KEYWORD, GROUP_KEYWORD, GROUP_KEYWORD,
      GROUP_KEYWORD, GROUP_KEYWORD, GROUP_KEYWORD,
      GROUP_CALL, GROUP_CALL, GROUP_CALL, GROUP_CALL, GROUP_CALL
   };
   localparam int WORD_SLOT [WORD_COUNT] = '{0, 0, 0, 1, 2, 3, 4, 5, 6, 0, 0, 0, 0, 0};

   typedef struct packed {
      logic [RATIO_BITS-1:0] semi_scale;
      logic [MIN_BITS-1:0]   lines_minimum;
      logic [MIN_BITS-1:0]   arrows_minimum;
      logic [MIN_BITS-1:0]   preproc_minimum;
      logic [MIN_BITS-1:0]   keywords_minimum;
      logic [MIN_BITS-1:0]   calls_minimum;
   } cfg_type;

   // final counts of one packet
   typedef struct packed {
      logic [COUNT_BITS-1:0]    lines;
      logic [COUNT_BITS-1:0]    semis;
      logic [COUNT_BITS-1:0]    arrows;
      logic [COUNT_BITS-1:0]    preproc;
      logic [COUNT_BITS-1:0]    calls;
      logic [KSUM_BITS-1:0]     ksum;
      logic [DISTINCT_BITS-1:0] distinct;
   } snap_type;

   typedef struct packed {
      logic                     is_c_code;
      logic [TOTAL_BITS-1:0]    line_total;
      logic [TOTAL_BITS-1:0]    semicolon_total;
      logic [TOTAL_BITS-1:0]    arrow_total;
      logic [TOTAL_BITS-1:0]    preproc_total;
      logic [SUM_BITS-1:0]      keyword_sum;
      logic [DIST_OUT_BITS-1:0] keyword_distinct;
      logic [TOTAL_BITS-1:0]    call_total;
   } result_type;

   // character j of word k, counted from the first character
   function automatic logic [BYTE_BITS-1:0] word_char(int k, int j);
      logic [BYTE_BITS-1:0] ch;
      ch = '0;
      if (j < WORD_LEN[k]) begin
         ch = WORD_TEXT[k][BYTE_BITS*(WORD_LEN[k]-1-j) +: BYTE_BITS];
      end
      return ch;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v, logic en);
      logic [COUNT_BITS-1:0] r;
      r = v;
      if (en && (v != '1)) begin
         r = v + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [TOTAL_BITS-1:0] fit_total(logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS+TOTAL_BITS-1:0] wide;
      wide = (COUNT_BITS+TOTAL_BITS)'(v);
      return wide[TOTAL_BITS-1:0];
   endfunction

   function automatic logic [SUM_BITS-1:0] fit_sum(logic [KSUM_BITS-1:0] v);
      logic [KSUM_BITS+SUM_BITS-1:0] wide;
      wide = (KSUM_BITS+SUM_BITS)'(v);
      return wide[SUM_BITS-1:0];
   endfunction

endpackage

### hdl/cspd_csr.sv
// Configuration registers of the C source payload detector.
module cspd_csr
   import cspd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SEMI_SCALE:       cfg_in.semi_scale       = csr_wdata[RATIO_BITS-1:0];
            CSR_LINES_MINIMUM:    cfg_in.lines_minimum    = csr_wdata[MIN_BITS-1:0];
            CSR_ARROWS_MINIMUM:   cfg_in.arrows_minimum   = csr_wdata[MIN_BITS-1:0];
            CSR_PREPROC_MINIMUM:  cfg_in.preproc_minimum  = csr_wdata[MIN_BITS-1:0];
            CSR_KEYWORDS_MINIMUM: cfg_in.keywords_minimum = csr_wdata[MIN_BITS-1:0];
            CSR_CALLS_MINIMUM:    cfg_in.calls_minimum    = csr_wdata[MIN_BITS-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.semi_scale       <= RATIO_BITS'(2);
         cfg_ff.lines_minimum    <= MIN_BITS'(10);
         cfg_ff.arrows_minimum   <= MIN_BITS'(3);
         cfg_ff.preproc_minimum  <= MIN_BITS'(2);
         cfg_ff.keywords_minimum <= MIN_BITS'(5);
         cfg_ff.calls_minimum    <= MIN_BITS'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/cspd_scan.sv
// Lookahead window, pattern compare and saturating feature counters.
module cspd_scan
   import cspd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_step,
   input  logic [BYTE_BITS-1:0] item_byte,
   input  logic                 item_last,
   output logic                 snap_load,
   output snap_type             snap_data
);

   logic [BYTE_BITS-1:0]     win_ff [BUF_LEN];
   logic [BYTE_BITS-1:0]     win_in [BUF_LEN];
   logic [FILL_BITS-1:0]     fill_ff, fill_in, fill_upd;
   logic [SKIP_BITS-1:0]     skip_ff, skip_in, skip_upd, skip_new;
   logic [COUNT_BITS-1:0]    lines_ff, semis_ff, arrows_ff, preproc_ff, calls_ff;
   logic [COUNT_BITS-1:0]    lines_in, semis_in, arrows_in, preproc_in, calls_in;
   logic [COUNT_BITS-1:0]    kw_ff [KW_COUNT];
   logic [COUNT_BITS-1:0]    kw_in [KW_COUNT];
   logic [COUNT_BITS-1:0]    kw_upd [KW_COUNT];
   logic [KSUM_BITS-1:0]     ksum_ff, ksum_in;
   logic [DISTINCT_BITS-1:0] distinct_ff, distinct_in;
   logic                     full, examine;
   logic [WORD_COUNT-1:0]    hit;
   logic                     word_hit;
   logic [WORD_IDX_BITS-1:0] word_idx;
   logic                     line_inc, semi_inc, arrow_inc, pre_inc, kw_inc, call_inc;
   logic [KW_IDX_BITS-1:0]   kw_slot;
   logic                     kw_bump, kw_first;
   snap_type                 upd;

   always_comb begin
      for (int i = 0; i < BUF_LEN - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[BUF_LEN-1] = item_byte;

      fill_upd = (fill_ff < FILL_BITS'(BUF_LEN)) ? fill_ff + 1'b1 : fill_ff;
      full     = (fill_upd == FILL_BITS'(BUF_LEN));
      examine  = item_step && full && (skip_ff == '0);

      // fixed-string compare at the head of the shifted window
      for (int k = 0; k < WORD_COUNT; k++) begin
         hit[k] = 1'b1;
         for (int j = 0; j < WORD_MAX_LEN; j++) begin
            if ((j < WORD_LEN[k]) && (win_in[j] != word_char(k, j))) begin
               hit[k] = 1'b0;
            end
         end
      end
      word_hit = |hit;
      word_idx = '0;
      for (int k = WORD_COUNT - 1; k >= 0; k--) begin
         if (hit[k]) begin
            word_idx = WORD_IDX_BITS'(k);
         end
      end

      line_inc  = 1'b0;
      semi_inc  = 1'b0;
      arrow_inc = 1'b0;
      pre_inc   = 1'b0;
      kw_inc    = 1'b0;
      call_inc  = 1'b0;
      skip_new  = '0;
      kw_slot   = KW_IDX_BITS'(WORD_SLOT[word_idx]);
      if (examine) begin
         priority if (win_in[0] == CHAR_LF) begin
            line_inc = 1'b1;
         end else if (win_in[0] == CHAR_SEMI) begin
            semi_inc = (win_in[1] == CHAR_LF) || (win_in[1] == CHAR_CR);
         end else if ((win_in[0] == CHAR_DASH) && (win_in[1] == CHAR_GT)) begin
            arrow_inc = 1'b1;
            skip_new  = SKIP_BITS'(1);
         end else if (word_hit) begin
            skip_new = SKIP_BITS'(WORD_LEN[word_idx] - 1);
            unique case (WORD_GROUP[word_idx])
               GROUP_PREPROC: pre_inc  = 1'b1;
               GROUP_KEYWORD: kw_inc   = 1'b1;
               GROUP_CALL:    call_inc = 1'b1;
               default:       call_inc = 1'b0;
            endcase
         end else begin
            skip_new = '0;
         end
      end

      priority if (!full) begin
         skip_upd = skip_ff;
      end else if (skip_ff != '0) begin
         skip_upd = skip_ff - 1'b1;
      end else begin
         skip_upd = skip_new;
      end

      kw_bump  = 1'b0;
      kw_first = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw_upd[k] = sat_inc(kw_ff[k], kw_inc && (kw_slot == KW_IDX_BITS'(k)));
         if (kw_inc && (kw_slot == KW_IDX_BITS'(k))) begin
            kw_bump  = (kw_ff[k] != '1);
            kw_first = (kw_ff[k] == '0);
         end
      end

      upd.lines    = sat_inc(lines_ff, line_inc);
      upd.semis    = sat_inc(semis_ff, semi_inc);
      upd.arrows   = sat_inc(arrows_ff, arrow_inc);
      upd.preproc  = sat_inc(preproc_ff, pre_inc);
      upd.calls    = sat_inc(calls_ff, call_inc);
      upd.ksum     = ksum_ff + KSUM_BITS'(kw_bump);
      upd.distinct = distinct_ff + DISTINCT_BITS'(kw_first);

      // hold when idle, clear after the last byte of a packet
      fill_in     = fill_ff;
      skip_in     = skip_ff;
      lines_in    = lines_ff;
      semis_in    = semis_ff;
      arrows_in   = arrows_ff;
      preproc_in  = preproc_ff;
      calls_in    = calls_ff;
      ksum_in     = ksum_ff;
      distinct_in = distinct_ff;
      kw_in       = kw_ff;
      if (item_step) begin
         if (item_last) begin
            fill_in     = '0;
            skip_in     = '0;
            lines_in    = '0;
            semis_in    = '0;
            arrows_in   = '0;
            preproc_in  = '0;
            calls_in    = '0;
            ksum_in     = '0;
            distinct_in = '0;
            for (int k = 0; k < KW_COUNT; k++) begin
               kw_in[k] = '0;
            end
         end else begin
            fill_in     = fill_upd;
            skip_in     = skip_upd;
            lines_in    = upd.lines;
            semis_in    = upd.semis;
            arrows_in   = upd.arrows;
            preproc_in  = upd.preproc;
            calls_in    = upd.calls;
            ksum_in     = upd.ksum;
            distinct_in = upd.distinct;
            kw_in       = kw_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         skip_ff     <= '0;
         lines_ff    <= '0;
         semis_ff    <= '0;
         arrows_ff   <= '0;
         preproc_ff  <= '0;
         calls_ff    <= '0;
         ksum_ff     <= '0;
         distinct_ff <= '0;
         for (int k = 0; k < KW_COUNT; k++) begin
            kw_ff[k] <= '0;
         end
      end else begin
         fill_ff     <= fill_in;
         skip_ff     <= skip_in;
         lines_ff    <= lines_in;
         semis_ff    <= semis_in;
         arrows_ff   <= arrows_in;
         preproc_ff  <= preproc_in;
         calls_ff    <= calls_in;
         ksum_ff     <= ksum_in;
         distinct_ff <= distinct_in;
         kw_ff       <= kw_in;
      end
   end

   // window bytes are only examined once fill_ff says they were all loaded
   always_ff @(posedge clock) begin
      if (item_step) begin
         win_ff <= win_in;
      end
   end

   assign snap_load = item_step && item_last;
   assign snap_data = upd;

endmodule

### hdl/cspd_verdict.sv
// Packet count snapshot, verdict rules and result register.
module cspd_verdict
   import cspd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     snap_load,
   input  snap_type snap_data,
   output logic     snap_free,
   input  logic     rsp_stall,
   output logic     rsp_valid,
   output result_type rsp_data
);

   logic       snap_valid_ff, snap_valid_in;
   snap_type   snap_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_free, snap_move;
   logic [PROD_BITS-1:0] semi_prod;
   logic       semi_rule, arrow_rule, pre_rule, kw_rule, call_rule;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign snap_move = snap_valid_ff && rsp_free;
   assign snap_free = !snap_valid_ff || snap_move;

   always_comb begin
      semi_prod  = PROD_BITS'(snap_ff.semis) * PROD_BITS'(cfg.semi_scale);
      semi_rule  = (semi_prod >= PROD_BITS'(snap_ff.lines)) &&
                   (CMP_BITS'(snap_ff.lines) >= CMP_BITS'(cfg.lines_minimum));
      arrow_rule = CMP_BITS'(snap_ff.arrows) >= CMP_BITS'(cfg.arrows_minimum);
      pre_rule   = CMP_BITS'(snap_ff.preproc) >= CMP_BITS'(cfg.preproc_minimum);
      kw_rule    = (CMP_BITS'(snap_ff.ksum) >= CMP_BITS'(cfg.keywords_minimum)) &&
                   (snap_ff.distinct > DISTINCT_BITS'(1));
      call_rule  = CMP_BITS'(snap_ff.calls) >= CMP_BITS'(cfg.calls_minimum);

      rsp_in.is_c_code        = semi_rule || arrow_rule || pre_rule || kw_rule || call_rule;
      rsp_in.line_total       = fit_total(snap_ff.lines);
      rsp_in.semicolon_total  = fit_total(snap_ff.semis);
      rsp_in.arrow_total      = fit_total(snap_ff.arrows);
      rsp_in.preproc_total    = fit_total(snap_ff.preproc);
      rsp_in.keyword_sum      = fit_sum(snap_ff.ksum);
      rsp_in.keyword_distinct = DIST_OUT_BITS'(snap_ff.distinct);
      rsp_in.call_total       = fit_total(snap_ff.calls);

      priority if (snap_load) begin
         snap_valid_in = 1'b1;
      end else if (snap_move) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end

      priority if (snap_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_ff <= snap_data;
      end
      if (snap_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/c_source_payload_detector.sv
// Top level of the C source payload detector: input register, scan, verdict and config.
//
// Takes one payload byte per word and can accept a word on every clock. Each byte is
// registered, then shifted into a 17-byte lookahead window; the byte 16 places behind
// the newest is checked for newline, line-ending semicolon, arrow and a fixed set of
// preprocessor, keyword and library-call strings, and a match skips the scan past the
// matched text. Counters saturate at 65535. A packet's last byte (packet_end) is checked
// too, then its counts move to a snapshot register, the verdict is formed there and one
// result word is then registered onto rsp_ through the result register; all packet state
// is cleared for the next packet. The window and counter update loop runs once per
// clock, so throughput is one byte per cycle. A stalled result holds back only a
// further last byte, once the snapshot register is also occupied. Configuration
// registers reset to ratio 2, lines 10, arrows 3, preprocessor 2, keywords 5, calls 3.
module c_source_payload_detector
   import cspd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [BYTE_BITS-1:0]      req_payload_byte,
   input  logic                      req_packet_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_is_c_code,
   output logic [TOTAL_BITS-1:0]     rsp_line_total,
   output logic [TOTAL_BITS-1:0]     rsp_semicolon_total,
   output logic [TOTAL_BITS-1:0]     rsp_arrow_total,
   output logic [TOTAL_BITS-1:0]     rsp_preproc_total,
   output logic [SUM_BITS-1:0]       rsp_keyword_sum,
   output logic [DIST_OUT_BITS-1:0]  rsp_keyword_distinct,
   output logic [TOTAL_BITS-1:0]     rsp_call_total,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 in_last_ff;
   logic                 advance, accept;
   logic                 snap_load, snap_free;
   snap_type             snap_data;
   cfg_type              cfg;
   result_type           rsp_data;

   // a last byte may only move on when the snapshot register can take its counts
   assign advance   = in_valid_ff && (!in_last_ff || snap_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      priority if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_payload_byte;
         in_last_ff <= req_packet_end;
      end
   end

   cspd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cspd_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .item_step (advance),
      .item_byte (in_byte_ff),
      .item_last (in_last_ff),
      .snap_load (snap_load),
      .snap_data (snap_data)
   );

   cspd_verdict u_verdict (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .snap_load (snap_load),
      .snap_data (snap_data),
      .snap_free (snap_free),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_is_c_code        = rsp_data.is_c_code;
   assign rsp_line_total       = rsp_data.line_total;
   assign rsp_semicolon_total  = rsp_data.semicolon_total;
   assign rsp_arrow_total      = rsp_data.arrow_total;
   assign rsp_preproc_total    = rsp_data.preproc_total;
   assign rsp_keyword_sum      = rsp_data.keyword_sum;
   assign rsp_keyword_distinct = rsp_data.keyword_distinct;
   assign rsp_call_total       = rsp_data.call_total;

`ifndef ASSERT_OFF
   // only a held last byte can back up the input side
   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff))
      else $error("input stalled without a pending last byte");

   a_no_keyword_no_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_keyword_distinct == '0)) |-> (rsp_keyword_sum == '0))
      else $error("keyword sum nonzero with no distinct keywords");

   a_arrow_rule: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_arrow_total >= cfg.arrows_minimum)) |-> rsp_is_c_code)
      else $error("arrow count reached minimum but verdict is clear");

   a_call_rule: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_call_total >= cfg.calls_minimum)) |-> rsp_is_c_code)
      else $error("call count reached minimum but verdict is clear");
`endif

endmodule

### bench/tb_c_source_payload_detector.sv
// Self-checking testbench of the C source payload detector: directed, register and random packets.
module tb_c_source_payload_detector
   import cspd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT    = 2_000_000;
   localparam int unsigned RANDOM_BYTES   = 1400;
   localparam int unsigned RANDOM_PACKETS = 10;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned DRAIN_CYCLES   = 4;
   localparam int          FIRST_KEYWORD  = 2;
   localparam logic [BYTE_BITS-1:0]      CHAR_SPACE   = 8'h20;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [BYTE_BITS-1:0]      req_payload_byte = '0;
   logic                      req_packet_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_is_c_code;
   logic [TOTAL_BITS-1:0]     rsp_line_total;
   logic [TOTAL_BITS-1:0]     rsp_semicolon_total;
   logic [TOTAL_BITS-1:0]     rsp_arrow_total;
   logic [TOTAL_BITS-1:0]     rsp_preproc_total;
   logic [SUM_BITS-1:0]       rsp_keyword_sum;
   logic [DIST_OUT_BITS-1:0]  rsp_keyword_distinct;
   logic [TOTAL_BITS-1:0]     rsp_call_total;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   c_source_payload_detector dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_payload_byte     (req_payload_byte),
      .req_packet_end       (req_packet_end),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_is_c_code        (rsp_is_c_code),
      .rsp_line_total       (rsp_line_total),
      .rsp_semicolon_total  (rsp_semicolon_total),
      .rsp_arrow_total      (rsp_arrow_total),
      .rsp_preproc_total    (rsp_preproc_total),
      .rsp_keyword_sum      (rsp_keyword_sum),
      .rsp_keyword_distinct (rsp_keyword_distinct),
      .rsp_call_total       (rsp_call_total),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // scan strings in priority order
   string scan_words [WORD_COUNT] = '{
      "#define", "#include",
      "struct ", "enum ", "typedef ", "sizeof", "volatile ", "goto ", "void ",
      "printf(", "strcmp(", "strlen(", "malloc(", "scanf("
   };
   word_group_type scan_kind [WORD_COUNT] = '{
      GROUP_PREPROC, GROUP_PREPROC,
      GROUP_KEYWORD, GROUP_KEYWORD, GROUP_KEYWORD, GROUP_KEYWORD,
      GROUP_KEYWORD, GROUP_KEYWORD, GROUP_KEYWORD,
      GROUP_CALL, GROUP_CALL, GROUP_CALL, GROUP_CALL, GROUP_CALL
   };

   // predictor state
   logic [BYTE_BITS-1:0]  win [BUF_LEN];
   int unsigned           filled;
   int unsigned           skip_left;
   logic [COUNT_BITS-1:0] n_lines, n_semis, n_arrows, n_preproc, n_calls;
   logic [COUNT_BITS-1:0] n_kw [KW_COUNT];
   cfg_type               cfg;

   result_type            pending_verdicts [$];
   logic [BYTE_BITS-1:0]  pkt_bytes [$];
   int unsigned           fail_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           send_gap_pct = 0;
   int unsigned           rsp_stall_pct = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic bit word_at_head(input int k);
      for (int j = 0; j < scan_words[k].len(); j++) begin
         if (win[j] != scan_words[k][j]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // examine the oldest window byte, return positions consumed
   function automatic int unsigned scan_head();
      if (win[0] == CHAR_LF) begin
         n_lines = bump(n_lines);
         return 1;
      end
      if (win[0] == CHAR_SEMI) begin
         if (win[1] == CHAR_LF || win[1] == CHAR_CR) n_semis = bump(n_semis);
         return 1;
      end
      if (win[0] == CHAR_DASH && win[1] == CHAR_GT) begin
         n_arrows = bump(n_arrows);
         return 2;
      end
      for (int k = 0; k < WORD_COUNT; k++) begin
         if (word_at_head(k)) begin
            case (scan_kind[k])
               GROUP_PREPROC: n_preproc = bump(n_preproc);
               GROUP_KEYWORD: n_kw[k-FIRST_KEYWORD] = bump(n_kw[k-FIRST_KEYWORD]);
               default:       n_calls = bump(n_calls);
            endcase
            return scan_words[k].len();
         end
      end
      return 1;
   endfunction

   task automatic clear_packet();
      for (int i = 0; i < BUF_LEN; i++) win[i] = '0;
      for (int i = 0; i < KW_COUNT; i++) n_kw[i] = '0;
      filled    = 0;
      skip_left = 0;
      n_lines   = '0;
      n_semis   = '0;
      n_arrows  = '0;
      n_preproc = '0;
      n_calls   = '0;
   endtask

   task automatic predict_word(input logic [BYTE_BITS-1:0] value, input logic last);
      result_type           verdict;
      logic [SUM_BITS-1:0]  ksum;
      logic [DIST_OUT_BITS-1:0] distinct;
      logic [PROD_BITS-1:0] prod;
      for (int i = 0; i < BUF_LEN - 1; i++) win[i] = win[i+1];
      win[BUF_LEN-1] = value;
      if (filled < BUF_LEN) filled++;
      if (filled >= BUF_LEN) begin
         if (skip_left > 0) skip_left--;
         else skip_left = scan_head() - 1;
      end
      if (last) begin
         ksum     = '0;
         distinct = '0;
         for (int i = 0; i < KW_COUNT; i++) begin
            ksum = ksum + SUM_BITS'(n_kw[i]);
            if (n_kw[i] != '0) distinct++;
         end
         prod = PROD_BITS'(n_semis) * PROD_BITS'(cfg.semi_scale);
         verdict.is_c_code = (prod >= PROD_BITS'(n_lines) && n_lines >= cfg.lines_minimum) ||
                             n_arrows >= cfg.arrows_minimum ||
                             n_preproc >= cfg.preproc_minimum ||
                             (ksum >= SUM_BITS'(cfg.keywords_minimum) && distinct > 1) ||
                             n_calls >= cfg.calls_minimum;
         verdict.line_total       = n_lines;
         verdict.semicolon_total  = n_semis;
         verdict.arrow_total      = n_arrows;
         verdict.preproc_total    = n_preproc;
         verdict.keyword_sum      = ksum;
         verdict.keyword_distinct = distinct;
         verdict.call_total       = n_calls;
         pending_verdicts.push_back(verdict);
         clear_packet();
      end
   endtask

   task automatic send_byte(input logic [BYTE_BITS-1:0] value, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= value;
      req_packet_end   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(value, last);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   // body followed by enough padding that every body byte gets examined
   task automatic send_packet(input string body);
      send_text(body);
      for (int i = 0; i < WINDOW; i++) send_byte(CHAR_SPACE, i == WINDOW - 1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_SEMI_SCALE:       cfg.semi_scale       = value[RATIO_BITS-1:0];
         CSR_LINES_MINIMUM:    cfg.lines_minimum    = value;
         CSR_ARROWS_MINIMUM:   cfg.arrows_minimum   = value;
         CSR_PREPROC_MINIMUM:  cfg.preproc_minimum  = value;
         CSR_KEYWORDS_MINIMUM: cfg.keywords_minimum = value;
         CSR_CALLS_MINIMUM:    cfg.calls_minimum    = value;
         default: ;
      endcase
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_minimum();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return CSR_DATA_BITS'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic add_fragment();
      int unsigned pick;
      int unsigned n;
      int          k;
      pick = $urandom_range(99);
      if (pick < 35) begin
         k = $urandom_range(WORD_COUNT - 1);
         n = scan_words[k].len();
         // truncated word: near miss
         if ($urandom_range(4) == 0) n = $urandom_range(1, n - 1);
         for (int j = 0; j < n; j++) pkt_bytes.push_back(scan_words[k][j]);
      end else if (pick < 50) begin
         pkt_bytes.push_back(CHAR_LF);
      end else if (pick < 62) begin
         pkt_bytes.push_back(CHAR_SEMI);
         case ($urandom_range(2))
            0:       pkt_bytes.push_back(CHAR_LF);
            1:       pkt_bytes.push_back(CHAR_CR);
            default: pkt_bytes.push_back(BYTE_BITS'($urandom_range(255)));
         endcase
      end else if (pick < 70) begin
         pkt_bytes.push_back(CHAR_DASH);
         if ($urandom_range(3) != 0) pkt_bytes.push_back(CHAR_GT);
         else pkt_bytes.push_back(BYTE_BITS'($urandom_range(255)));
      end else if (pick < 82) begin
         repeat ($urandom_range(1, 3)) pkt_bytes.push_back(CHAR_SPACE);
      end else begin
         pkt_bytes.push_back(BYTE_BITS'($urandom_range(255)));
      end
   endtask

   task automatic send_random_packet(output int unsigned len);
      int unsigned r;
      pkt_bytes.delete();
      r = $urandom_range(99);
      if (r < 10) len = $urandom_range(1, WINDOW);
      else if (r < 95) len = $urandom_range(WINDOW + 1, 64);
      else len = $urandom_range(65, 200);
      while (pkt_bytes.size() < len) add_fragment();
      for (int i = 0; i < len; i++) send_byte(pkt_bytes[i], i == len - 1);
   endtask

   task automatic test_short_packets();
      send_byte(CHAR_LF, 1'b1);
      send_byte(CHAR_LF, 1'b1);
      // window-sized packet: nothing examined
      for (int i = 0; i < WINDOW; i++) send_byte(CHAR_LF, i == WINDOW - 1);
      // one byte more: the last byte triggers the first examination
      for (int i = 0; i <= WINDOW; i++) send_byte(CHAR_LF, i == WINDOW);
   endtask

   task automatic test_tokens();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_packet({"#define X\n#include <y>\nstruct s; enum e;\015typedef t sizeof(x)\n",
                   "volatile int v; goto out;\nvoid f(a->b->c);\n",
                   "printf(strcmp(strlen(malloc(scanf(x;\n"});
      send_packet({"#defin #includ struct\tenum(typedefsizeo volatile\n",
                   "got voi- >;;x;;\015- ->> printf strcmp ( scan(\n"});
   endtask

   task automatic test_registers();
      wait_drained();
      // ratio zero: the semicolon rule holds only without lines
      write_reg(CSR_SEMI_SCALE, '0);
      write_reg(CSR_LINES_MINIMUM, '0);
      write_reg(CSR_ARROWS_MINIMUM, '1);
      write_reg(CSR_PREPROC_MINIMUM, '1);
      write_reg(CSR_KEYWORDS_MINIMUM, '1);
      write_reg(CSR_CALLS_MINIMUM, '1);
      send_packet("x;y");
      send_packet("a;\nb\n");
      wait_drained();
      // upper byte of the ratio is dropped; spare indexes must not disturb anything
      write_reg(CSR_SEMI_SCALE, 16'ha503);
      write_reg(CSR_LINES_MINIMUM, 16'd2);
      write_reg(CSR_SPARE_LO, '0);
      write_reg(CSR_SPARE_HI, '1);
      send_packet("a;\nb;\nc\nd\ne\nf\n");
      send_packet("a;\nb;\nc\nd\ne\nf\ng\n");
      wait_drained();
      write_reg(CSR_SEMI_SCALE, '1);
      write_reg(CSR_LINES_MINIMUM, '0);
      write_reg(CSR_ARROWS_MINIMUM, '0);
      write_reg(CSR_PREPROC_MINIMUM, '0);
      write_reg(CSR_KEYWORDS_MINIMUM, '0);
      write_reg(CSR_CALLS_MINIMUM, '0);
      send_byte(8'h00, 1'b1);
      send_packet("goto x; void y;");
   endtask

   task automatic run_random_phase(input int unsigned gap_pct, input int unsigned stall_pct);
      int unsigned bytes_sent;
      int unsigned packets;
      int unsigned len;
      wait_drained();
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      write_reg(CSR_SEMI_SCALE,
                {8'($urandom), ($urandom_range(3) == 0) ? 8'hff : 8'($urandom_range(0, 4))});
      write_reg(CSR_LINES_MINIMUM, pick_minimum());
      write_reg(CSR_ARROWS_MINIMUM, pick_minimum());
      write_reg(CSR_PREPROC_MINIMUM, pick_minimum());
      write_reg(CSR_KEYWORDS_MINIMUM, pick_minimum());
      write_reg(CSR_CALLS_MINIMUM, pick_minimum());
      bytes_sent = 0;
      packets    = 0;
      while (bytes_sent < RANDOM_BYTES / 3 || packets < RANDOM_PACKETS) begin
         send_random_packet(len);
         bytes_sent += len;
         packets++;
         // hold off until every verdict is back
         if ($urandom_range(9) == 0) wait_drained();
      end
   endtask

   task automatic test_random();
      run_random_phase(15, 77);
      run_random_phase(77, 15);
      run_random_phase(0, 0);
   endtask

   function automatic string show(input result_type r);
      return $sformatf("c=%0d lines=%0d semis=%0d arrows=%0d preproc=%0d kw=%0d/%0d calls=%0d",
                       r.is_c_code, r.line_total, r.semicolon_total, r.arrow_total,
                       r.preproc_total, r.keyword_sum, r.keyword_distinct, r.call_total);
   endfunction

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_is_c_code, rsp_line_total, rsp_semicolon_total, rsp_arrow_total,
                rsp_preproc_total, rsp_keyword_sum, rsp_keyword_distinct, rsp_call_total};
         if (pending_verdicts.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) $display("unexpected result word: %s", show(got));
         end else begin
            want = pending_verdicts.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("result mismatch at %0t", $realtime);
                  $display("  expected %s", show(want));
                  $display("  actual   %s", show(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      cfg = '{semi_scale: 8'd2, lines_minimum: 16'd10, arrows_minimum: 16'd3,
              preproc_minimum: 16'd2, keywords_minimum: 16'd5, calls_minimum: 16'd3};
      clear_packet();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_gap_pct  = 15;
      rsp_stall_pct = 77;
      test_short_packets();
      test_tokens();
      test_registers();
      test_random();
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_verdicts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/cspd_pkg.sv
hdl/cspd_csr.sv
hdl/cspd_scan.sv
hdl/cspd_verdict.sv
hdl/c_source_payload_detector.sv
bench/tb_c_source_payload_detector.sv
